/* hdl/asam_pkg.sv */
package asam_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 12;
  localparam int ALPHA_W     = 17;
  localparam int ANGLE_CFG_W = 17;
  localparam int ANGLE_W     = 24;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int MUL_A_W  = 18;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int FRAC_W   = 16;

  localparam int DIV_NUM_W  = 30;
  localparam int DIV_REM_W  = LEVEL_W;
  localparam int DIV_STEPS  = DIV_NUM_W / 2;
  localparam int DIV_CNT_W  = 4;
  localparam int QUOT_W     = DIV_NUM_W + 2;
  localparam int MAP_SUM_W  = QUOT_W + 1;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [ALPHA_W-1:0]            ONE_Q16         = 17'h10000;
  localparam logic [ALPHA_W-1:0]            ALPHA_RST       = 17'd32768;
  localparam logic [LEVEL_W-1:0]            MIN_LEVEL_RST   = 12'd1550;
  localparam logic [LEVEL_W-1:0]            MAX_LEVEL_RST   = 12'd2150;
  localparam logic [LEVEL_W-1:0]            START_LEVEL_RST = 12'd1850;
  localparam logic signed [ANGLE_CFG_W-1:0] MIN_ANGLE_RST   = -17'sd23040;
  localparam logic signed [ANGLE_CFG_W-1:0] MAX_ANGLE_RST   = 17'sd23040;

  typedef enum logic [2:0] {
    REG_ALPHA       = 3'd0,
    REG_MIN_LEVEL   = 3'd1,
    REG_MAX_LEVEL   = 3'd2,
    REG_START_LEVEL = 3'd3,
    REG_MIN_ANGLE   = 3'd4,
    REG_MAX_ANGLE   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [ALPHA_W-1:0]            alpha;
    logic [LEVEL_W-1:0]            min_level;
    logic [LEVEL_W-1:0]            max_level;
    logic signed [ANGLE_CFG_W-1:0] min_angle;
    logic signed [ANGLE_CFG_W-1:0] max_angle;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LVL_A,
    OP_LVL_B,
    OP_LVL_SUM,
    OP_MAP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_QUOT_FIX,
    OP_MAP_FIX,
    OP_ANG_A,
    OP_ANG_B,
    OP_ANG_SUM,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic range_err;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LVL_A,
    ST_LVL_B,
    ST_LVL_SUM,
    ST_MAP_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_QUOT_FIX,
    ST_MAP_FIX,
    ST_ANG_A,
    ST_ANG_B,
    ST_ANG_SUM,
    ST_OUT
  } state_e;

endpackage

/* hdl/asam_regs.sv */
module asam_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [asam_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [asam_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [asam_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output asam_pkg::cfg_t                        cfg_o
);

  logic [asam_pkg::ALPHA_W-1:0]            alpha_q;
  logic [asam_pkg::LEVEL_W-1:0]            min_level_q;
  logic [asam_pkg::LEVEL_W-1:0]            max_level_q;
  logic [asam_pkg::LEVEL_W-1:0]            start_level_q;
  logic signed [asam_pkg::ANGLE_CFG_W-1:0] min_angle_q;
  logic signed [asam_pkg::ANGLE_CFG_W-1:0] max_angle_q;
  logic [2:0]                              idx;
  logic                                    wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q       <= asam_pkg::ALPHA_RST;
      min_level_q   <= asam_pkg::MIN_LEVEL_RST;
      max_level_q   <= asam_pkg::MAX_LEVEL_RST;
      start_level_q <= asam_pkg::START_LEVEL_RST;
      min_angle_q   <= asam_pkg::MIN_ANGLE_RST;
      max_angle_q   <= asam_pkg::MAX_ANGLE_RST;
    end else if (wr_en) begin
      case (idx)
        asam_pkg::REG_ALPHA:       alpha_q       <= pwdata[asam_pkg::ALPHA_W-1:0];
        asam_pkg::REG_MIN_LEVEL:   min_level_q   <= pwdata[asam_pkg::LEVEL_W-1:0];
        asam_pkg::REG_MAX_LEVEL:   max_level_q   <= pwdata[asam_pkg::LEVEL_W-1:0];
        asam_pkg::REG_START_LEVEL: start_level_q <= pwdata[asam_pkg::LEVEL_W-1:0];
        asam_pkg::REG_MIN_ANGLE:   min_angle_q   <= $signed(pwdata[asam_pkg::ANGLE_CFG_W-1:0]);
        asam_pkg::REG_MAX_ANGLE:   max_angle_q   <= $signed(pwdata[asam_pkg::ANGLE_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      asam_pkg::REG_ALPHA:       prdata = 32'(alpha_q);
      asam_pkg::REG_MIN_LEVEL:   prdata = 32'(min_level_q);
      asam_pkg::REG_MAX_LEVEL:   prdata = 32'(max_level_q);
      asam_pkg::REG_START_LEVEL: prdata = 32'(start_level_q);
      asam_pkg::REG_MIN_ANGLE:   prdata = 32'(min_angle_q);
      asam_pkg::REG_MAX_ANGLE:   prdata = 32'(max_angle_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.alpha     = alpha_q;
  assign cfg_o.min_level = min_level_q;
  assign cfg_o.max_level = max_level_q;
  assign cfg_o.min_angle = min_angle_q;
  assign cfg_o.max_angle = max_angle_q;

endmodule

/* hdl/asam_ctrl.sv */
module asam_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  asam_pkg::sts_t sts_i,
  output asam_pkg::cmd_t cmd_o
);

  asam_pkg::state_e                 state_q, state_d;
  logic [asam_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asam_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = asam_pkg::OP_NONE;
    case (state_q)
      asam_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = asam_pkg::OP_LOAD;
          state_d  = asam_pkg::ST_LVL_A;
        end
      end
      asam_pkg::ST_LVL_A: begin
        cmd_o.op = asam_pkg::OP_LVL_A;
        state_d  = asam_pkg::ST_LVL_B;
      end
      asam_pkg::ST_LVL_B: begin
        cmd_o.op = asam_pkg::OP_LVL_B;
        state_d  = asam_pkg::ST_LVL_SUM;
      end
      asam_pkg::ST_LVL_SUM: begin
        cmd_o.op = asam_pkg::OP_LVL_SUM;
        state_d  = asam_pkg::ST_MAP_MUL;
      end
      asam_pkg::ST_MAP_MUL: begin
        cmd_o.op = asam_pkg::OP_MAP_MUL;
        state_d  = asam_pkg::ST_DIV_INIT;
      end
      asam_pkg::ST_DIV_INIT: begin
        cmd_o.op = asam_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = sts_i.range_err ? asam_pkg::ST_MAP_FIX : asam_pkg::ST_DIV;
      end
      asam_pkg::ST_DIV: begin
        cmd_o.op = asam_pkg::OP_DIV_STEP;
        if (cnt_q == asam_pkg::DIV_LAST) begin
          state_d = asam_pkg::ST_QUOT_FIX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      asam_pkg::ST_QUOT_FIX: begin
        cmd_o.op = asam_pkg::OP_QUOT_FIX;
        state_d  = asam_pkg::ST_MAP_FIX;
      end
      asam_pkg::ST_MAP_FIX: begin
        cmd_o.op = asam_pkg::OP_MAP_FIX;
        state_d  = asam_pkg::ST_ANG_A;
      end
      asam_pkg::ST_ANG_A: begin
        cmd_o.op = asam_pkg::OP_ANG_A;
        state_d  = asam_pkg::ST_ANG_B;
      end
      asam_pkg::ST_ANG_B: begin
        cmd_o.op = asam_pkg::OP_ANG_B;
        state_d  = asam_pkg::ST_ANG_SUM;
      end
      asam_pkg::ST_ANG_SUM: begin
        cmd_o.op = asam_pkg::OP_ANG_SUM;
        state_d  = asam_pkg::ST_OUT;
      end
      asam_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = asam_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = asam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = asam_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == asam_pkg::ST_LVL_A))
    else $error("accepted transaction did not start processing");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asam_pkg::ST_OUT && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && state_q == asam_pkg::ST_IDLE))
    else $error("result not presented after output slot freed");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asam_pkg::ST_DIV) |-> (cnt_q <= asam_pkg::DIV_LAST))
    else $error("divider step count out of range");

  a_div_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asam_pkg::ST_DIV_INIT && sts_i.range_err)
      |=> (state_q == asam_pkg::ST_MAP_FIX))
    else $error("empty level range did not bypass divider");
`endif

endmodule

/* hdl/asam_datapath.sv */
module asam_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  asam_pkg::cfg_t                         cfg_i,
  input  asam_pkg::cmd_t                         cmd_i,
  output asam_pkg::sts_t                         sts_o,
  input  logic [asam_pkg::SAMPLE_W-1:0]          sample_i,
  output logic [asam_pkg::LEVEL_W-1:0]           level_out_o,
  output logic signed [asam_pkg::ANGLE_W-1:0]    angle_out_o,
  output logic                                   range_error_o
);

  localparam int PW = asam_pkg::PROD_W;
  localparam int AW = asam_pkg::ANGLE_W;
  localparam int SW = asam_pkg::MAP_SUM_W;
  localparam int FW = asam_pkg::FRAC_W;
  localparam int RW = asam_pkg::DIV_REM_W;
  localparam int NW = asam_pkg::DIV_NUM_W;

  // smoothed state
  logic [asam_pkg::LEVEL_W-1:0] lvl_state_q;
  logic signed [AW-1:0]         ang_state_q;

  logic [asam_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [PW-1:0]          prod_q, acc_q;
  logic [NW-1:0]                 num_q;
  logic [RW-1:0]                 rem_q;
  logic                          neg_q;
  logic                          err_q;
  logic signed [asam_pkg::QUOT_W-1:0] quot_q;
  logic signed [AW-1:0]          mapped_q;
  logic [asam_pkg::LEVEL_W-1:0]  level_out_q;
  logic signed [AW-1:0]          angle_out_q;
  logic                          err_out_q;

  logic [asam_pkg::ALPHA_W-1:0]  alpha_eff, ualpha;
  logic                          range_err;
  logic [RW-1:0]                 den;
  logic signed [asam_pkg::LEVEL_W:0]     dl;
  logic signed [asam_pkg::ANGLE_CFG_W:0] da;
  logic signed [asam_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [asam_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          sum;
  logic [PW-1:0]                 prod_mag;
  logic [RW:0]                   r1, r1n, r2, r2n;
  logic                          ge1, ge2;
  logic [NW-1:0]                 n1, n2;
  logic [asam_pkg::QUOT_W-1:0]   qmag;
  logic signed [asam_pkg::QUOT_W-1:0] quot_d;
  logic signed [SW-1:0]          msum;
  logic                          fits;
  logic signed [AW-1:0]          mapped_d;

  assign alpha_eff = (cfg_i.alpha > asam_pkg::ONE_Q16) ? asam_pkg::ONE_Q16 : cfg_i.alpha;
  assign ualpha    = asam_pkg::ONE_Q16 - alpha_eff;
  assign range_err = cfg_i.max_level <= cfg_i.min_level;
  assign den       = cfg_i.max_level - cfg_i.min_level;
  assign dl = $signed({1'b0, lvl_state_q}) - $signed({1'b0, cfg_i.min_level});
  assign da = $signed({cfg_i.max_angle[asam_pkg::ANGLE_CFG_W-1], cfg_i.max_angle})
            - $signed({cfg_i.min_angle[asam_pkg::ANGLE_CFG_W-1], cfg_i.min_angle});

  always_comb begin
    case (cmd_i.op)
      asam_pkg::OP_LVL_A: begin
        mul_a = $signed({1'b0, alpha_eff});
        mul_b = $signed({13'b0, sample_q});
      end
      asam_pkg::OP_LVL_B: begin
        mul_a = $signed({1'b0, ualpha});
        mul_b = $signed({13'b0, lvl_state_q});
      end
      asam_pkg::OP_MAP_MUL: begin
        mul_a = $signed({{5{dl[asam_pkg::LEVEL_W]}}, dl});
        mul_b = $signed({{7{da[asam_pkg::ANGLE_CFG_W]}}, da});
      end
      asam_pkg::OP_ANG_A: begin
        mul_a = $signed({1'b0, alpha_eff});
        mul_b = $signed({mapped_q[AW-1], mapped_q});
      end
      asam_pkg::OP_ANG_B: begin
        mul_a = $signed({1'b0, ualpha});
        mul_b = $signed({ang_state_q[AW-1], ang_state_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign sum      = acc_q + prod_q;
  assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);

  // two restoring division steps per cycle
  assign r1  = {rem_q, num_q[NW-1]};
  assign ge1 = r1 >= {1'b0, den};
  assign r1n = ge1 ? r1 - {1'b0, den} : r1;
  assign n1  = {num_q[NW-2:0], ge1};
  assign r2  = {r1n[RW-1:0], n1[NW-1]};
  assign ge2 = r2 >= {1'b0, den};
  assign r2n = ge2 ? r2 - {1'b0, den} : r2;
  assign n2  = {n1[NW-2:0], ge2};

  // floor toward minus infinity
  assign qmag   = {2'b00, num_q};
  assign quot_d = !neg_q ? $signed(qmag)
                : ((rem_q != '0) ? $signed(~qmag) : -$signed(qmag));

  assign msum = $signed({{(SW-asam_pkg::ANGLE_CFG_W){cfg_i.min_angle[asam_pkg::ANGLE_CFG_W-1]}},
                         cfg_i.min_angle})
              + $signed({quot_q[asam_pkg::QUOT_W-1], quot_q});
  assign fits = (msum[SW-1:AW-1] == '0) || (msum[SW-1:AW-1] == '1);
  assign mapped_d = fits ? msum[AW-1:0]
                  : (msum[SW-1] ? $signed({1'b1, {(AW-1){1'b0}}})
                                : $signed({1'b0, {(AW-1){1'b1}}}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_state_q <= asam_pkg::START_LEVEL_RST;
      ang_state_q <= '0;
    end else begin
      if (cmd_i.op == asam_pkg::OP_LVL_SUM) begin
        lvl_state_q <= sum[FW+asam_pkg::LEVEL_W-1:FW];
      end
      if (cmd_i.op == asam_pkg::OP_ANG_SUM) begin
        ang_state_q <= sum[FW+AW-1:FW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (cmd_i.op)
      asam_pkg::OP_LOAD: begin
        sample_q <= sample_i;
      end
      asam_pkg::OP_LVL_B, asam_pkg::OP_ANG_B: begin
        acc_q <= prod_q;
      end
      asam_pkg::OP_DIV_INIT: begin
        neg_q <= prod_q[PW-1];
        num_q <= prod_mag[NW-1:0];
        rem_q <= '0;
        err_q <= range_err;
        if (range_err) begin
          quot_q <= '0;
        end
      end
      asam_pkg::OP_DIV_STEP: begin
        num_q <= n2;
        rem_q <= r2n[RW-1:0];
      end
      asam_pkg::OP_QUOT_FIX: begin
        quot_q <= quot_d;
      end
      asam_pkg::OP_MAP_FIX: begin
        mapped_q <= mapped_d;
      end
      asam_pkg::OP_OUT: begin
        level_out_q <= lvl_state_q;
        angle_out_q <= ang_state_q;
        err_out_q   <= err_q;
      end
      default: ;
    endcase
  end

  assign sts_o.range_err = range_err;
  assign level_out_o     = level_out_q;
  assign angle_out_o     = angle_out_q;
  assign range_error_o   = err_out_q;

endmodule

/* hdl/adc_smoothed_angle_mapper_top.sv */
// Smooths 12-bit converter samples with an exponential filter, maps the smoothed level
// linearly onto an angle range (signed Q8 degrees, saturated to 24 bits) and smooths that
// angle with the same weight. Each sample uses the single shared 18x25 multiplier,
// five times per sample, and a divider that retires two quotient bits per cycle and
// is skipped when max_level is not above min_level; a new sample is accepted only once
// the last one is through and its result is stored. A finished result
// waits in an output register while the next sample is processed. Registers sit at byte
// addresses 0x00 alpha, 0x04 min_level, 0x08 max_level, 0x0c start_level, 0x10 min_angle,
// 0x14 max_angle and should be written only while the block is idle.
module adc_smoothed_angle_mapper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [asam_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [asam_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [asam_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [asam_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [asam_pkg::LEVEL_W-1:0]        level_out_o,
  output logic signed [asam_pkg::ANGLE_W-1:0] angle_out_o,
  output logic                                range_error_o
);

  asam_pkg::cfg_t cfg;
  asam_pkg::cmd_t cmd;
  asam_pkg::sts_t sts;

  asam_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  asam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  asam_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (sample_i),
    .level_out_o   (level_out_o),
    .angle_out_o   (angle_out_o),
    .range_error_o (range_error_o)
  );

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_SAMPLES = 100;
  localparam int     LONG_HOLD     = 400;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     REG_SPARE_A   = 6;
  localparam int     REG_SPARE_B   = 7;
  localparam int     SAMPLE_MAX    = (1 << asam_pkg::SAMPLE_W) - 1;
  localparam longint LEVEL_HI      = (longint'(1) << asam_pkg::LEVEL_W) - 1;
  localparam longint ANGLE_HI      = (longint'(1) <<< (asam_pkg::ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO      = -(longint'(1) <<< (asam_pkg::ANGLE_W - 1));

  typedef struct {
    logic [asam_pkg::LEVEL_W-1:0]        level;
    logic signed [asam_pkg::ANGLE_W-1:0] angle;
    logic                                range_err;
  } filter_result_t;

  logic                                clk = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [asam_pkg::APB_ADDR_W-1:0]     paddr = '0;
  logic [asam_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [asam_pkg::APB_DATA_W-1:0]     prdata;
  logic                                pready;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic [asam_pkg::SAMPLE_W-1:0]       sample_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [asam_pkg::LEVEL_W-1:0]        level_out_o;
  logic signed [asam_pkg::ANGLE_W-1:0] angle_out_o;
  logic                                range_error_o;

  logic [asam_pkg::ALPHA_W-1:0]            cfg_alpha       = asam_pkg::ALPHA_RST;
  logic [asam_pkg::LEVEL_W-1:0]            cfg_min_level   = asam_pkg::MIN_LEVEL_RST;
  logic [asam_pkg::LEVEL_W-1:0]            cfg_max_level   = asam_pkg::MAX_LEVEL_RST;
  logic [asam_pkg::LEVEL_W-1:0]            cfg_start_level = asam_pkg::START_LEVEL_RST;
  logic signed [asam_pkg::ANGLE_CFG_W-1:0] cfg_min_angle   = asam_pkg::MIN_ANGLE_RST;
  logic signed [asam_pkg::ANGLE_CFG_W-1:0] cfg_max_angle   = asam_pkg::MAX_ANGLE_RST;

  logic [asam_pkg::LEVEL_W-1:0]        level_state = asam_pkg::START_LEVEL_RST;
  logic signed [asam_pkg::ANGLE_W-1:0] angle_state = '0;

  filter_result_t pending_results[$];
  filter_result_t oldest_result;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             stall_left = 0;
  bit             no_idle = 1'b0;
  bit             long_hold_req = 1'b0;

  adc_smoothed_angle_mapper_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_out_o  (level_out_o),
    .angle_out_o  (angle_out_o),
    .range_error_o(range_error_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) begin
      q -= 1;
    end
    return q;
  endfunction

  function automatic longint clamp_angle(longint v);
    if (v > ANGLE_HI) begin
      return ANGLE_HI;
    end
    if (v < ANGLE_LO) begin
      return ANGLE_LO;
    end
    return v;
  endfunction

  function automatic filter_result_t smooth_and_map(logic [asam_pkg::SAMPLE_W-1:0] sample);
    longint a;
    longint ua;
    longint lvl;
    longint num;
    longint den;
    longint mapped;
    longint ang;
    filter_result_t r;
    a  = (cfg_alpha > asam_pkg::ONE_Q16) ? longint'(asam_pkg::ONE_Q16) : longint'(cfg_alpha);
    ua = longint'(asam_pkg::ONE_Q16) - a;
    lvl = (a * longint'(sample) + ua * longint'(level_state)) >>> asam_pkg::FRAC_W;
    if (lvl > LEVEL_HI) begin
      lvl = LEVEL_HI;
    end
    r.range_err = 1'b0;
    if (cfg_max_level <= cfg_min_level) begin
      mapped = longint'(cfg_min_angle);
      r.range_err = 1'b1;
    end else begin
      num = (lvl - longint'(cfg_min_level)) *
            (longint'(cfg_max_angle) - longint'(cfg_min_angle));
      den = longint'(cfg_max_level) - longint'(cfg_min_level);
      mapped = longint'(cfg_min_angle) + floor_quot(num, den);
    end
    mapped = clamp_angle(mapped);
    ang = clamp_angle(floor_quot(a * mapped + ua * longint'(angle_state),
                                 longint'(asam_pkg::ONE_Q16)));
    level_state = lvl[asam_pkg::LEVEL_W-1:0];
    angle_state = ang[asam_pkg::ANGLE_W-1:0];
    r.level = lvl[asam_pkg::LEVEL_W-1:0];
    r.angle = ang[asam_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // prediction on input transactions, comparison on output transactions
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(smooth_and_map(sample_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending, level %0d angle %0d",
                                    level_out_o, angle_out_o));
        end else begin
          oldest_result = pending_results.pop_front();
          if (level_out_o !== oldest_result.level) begin
            report_mismatch($sformatf("level_out got %0d want %0d",
                                      level_out_o, oldest_result.level));
          end
          if (angle_out_o !== oldest_result.angle) begin
            report_mismatch($sformatf("angle_out got %0d want %0d",
                                      angle_out_o, oldest_result.angle));
          end
          if (range_error_o !== oldest_result.range_err) begin
            report_mismatch($sformatf("range_error got %0b want %0b",
                                      range_error_o, oldest_result.range_err));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        stall_left = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (long_hold_req) begin
        stall_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(int idx, logic [asam_pkg::APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= asam_pkg::APB_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      asam_pkg::REG_ALPHA:       cfg_alpha       = data[asam_pkg::ALPHA_W-1:0];
      asam_pkg::REG_MIN_LEVEL:   cfg_min_level   = data[asam_pkg::LEVEL_W-1:0];
      asam_pkg::REG_MAX_LEVEL:   cfg_max_level   = data[asam_pkg::LEVEL_W-1:0];
      asam_pkg::REG_START_LEVEL: cfg_start_level = data[asam_pkg::LEVEL_W-1:0];
      asam_pkg::REG_MIN_ANGLE:   cfg_min_angle   = data[asam_pkg::ANGLE_CFG_W-1:0];
      asam_pkg::REG_MAX_ANGLE:   cfg_max_angle   = data[asam_pkg::ANGLE_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_read_check(int idx);
    logic [asam_pkg::APB_DATA_W-1:0] mask;
    logic [asam_pkg::APB_DATA_W-1:0] want;
    logic [asam_pkg::APB_DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= asam_pkg::APB_ADDR_W'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    mask = {asam_pkg::APB_DATA_W{1'b1}} >> (asam_pkg::APB_DATA_W - asam_pkg::LEVEL_W);
    want = '0;
    case (idx)
      asam_pkg::REG_ALPHA: begin
        want = asam_pkg::APB_DATA_W'(cfg_alpha);
        mask = {asam_pkg::APB_DATA_W{1'b1}} >> (asam_pkg::APB_DATA_W - asam_pkg::ALPHA_W);
      end
      asam_pkg::REG_MIN_LEVEL:   want = asam_pkg::APB_DATA_W'(cfg_min_level);
      asam_pkg::REG_MAX_LEVEL:   want = asam_pkg::APB_DATA_W'(cfg_max_level);
      asam_pkg::REG_START_LEVEL: want = asam_pkg::APB_DATA_W'(cfg_start_level);
      asam_pkg::REG_MIN_ANGLE: begin
        want = asam_pkg::APB_DATA_W'(cfg_min_angle);
        mask = {asam_pkg::APB_DATA_W{1'b1}} >>
               (asam_pkg::APB_DATA_W - asam_pkg::ANGLE_CFG_W);
      end
      asam_pkg::REG_MAX_ANGLE: begin
        want = asam_pkg::APB_DATA_W'(cfg_max_angle);
        mask = {asam_pkg::APB_DATA_W{1'b1}} >>
               (asam_pkg::APB_DATA_W - asam_pkg::ANGLE_CFG_W);
      end
      default: ;
    endcase
    if ((got & mask) !== (want & mask)) begin
      report_mismatch($sformatf("register %0d read 0x%0h want 0x%0h",
                                idx, got & mask, want & mask));
    end
  endtask

  task automatic check_all_registers();
    for (int i = asam_pkg::REG_ALPHA; i <= asam_pkg::REG_MAX_ANGLE; i++) begin
      reg_read_check(i);
    end
  endtask

  task automatic offer_sample(logic [asam_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [asam_pkg::SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2: v = int'(cfg_min_level) + int'($urandom_range(0, 8)) - 4;
      3: v = int'(cfg_max_level) + int'($urandom_range(0, 8)) - 4;
      default: v = $urandom_range(0, SAMPLE_MAX);
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    return v[asam_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic int random_angle();
    if ($urandom_range(0, 7) == 0) begin
      return int'($urandom_range(0, (1 << asam_pkg::ANGLE_CFG_W) - 1))
             - (1 << (asam_pkg::ANGLE_CFG_W - 1));
    end
    return int'($urandom_range(0, 92160)) - 46080;
  endfunction

  task automatic random_config();
    int lo;
    int hi;
    case ($urandom_range(0, 5))
      0: reg_write(asam_pkg::REG_ALPHA, 0);
      1: reg_write(asam_pkg::REG_ALPHA, asam_pkg::ONE_Q16);
      2: reg_write(asam_pkg::REG_ALPHA, $urandom_range(int'(asam_pkg::ONE_Q16) + 1,
                                                       (1 << asam_pkg::ALPHA_W) - 1));
      3: reg_write(asam_pkg::REG_ALPHA, $urandom_range(1, 4095));
      default: reg_write(asam_pkg::REG_ALPHA, $urandom_range(1, int'(asam_pkg::ONE_Q16) - 1));
    endcase
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, SAMPLE_MAX);
        hi = $urandom_range(0, lo);
      end
      1: begin
        lo = $urandom_range(0, SAMPLE_MAX - 3);
        hi = lo + int'($urandom_range(1, 3));
      end
      default: begin
        lo = $urandom_range(0, 3000);
        hi = $urandom_range(lo + 1, SAMPLE_MAX);
      end
    endcase
    reg_write(asam_pkg::REG_MIN_LEVEL, lo);
    reg_write(asam_pkg::REG_MAX_LEVEL, hi);
    reg_write(asam_pkg::REG_START_LEVEL, $urandom_range(0, SAMPLE_MAX));
    reg_write(asam_pkg::REG_MIN_ANGLE, random_angle());
    reg_write(asam_pkg::REG_MAX_ANGLE, random_angle());
    check_all_registers();
  endtask

  task automatic test_register_access();
    check_all_registers();
    reg_write(REG_SPARE_A, $urandom());
    reg_write(REG_SPARE_B, $urandom());
    check_all_registers();
  endtask

  task automatic test_reset_mapping();
    offer_sample(0);
    offer_sample(SAMPLE_MAX);
    offer_sample(1850);
    offer_sample(2150);
    wait_results_drained();
  endtask

  task automatic test_alpha_extremes();
    reg_write(asam_pkg::REG_ALPHA, 0);
    offer_sample(SAMPLE_MAX);
    offer_sample(0);
    wait_results_drained();
    reg_write(asam_pkg::REG_ALPHA, asam_pkg::ONE_Q16);
    offer_sample(2150);
    offer_sample(1550);
    wait_results_drained();
    reg_write(asam_pkg::REG_ALPHA, {asam_pkg::ALPHA_W{1'b1}});
    offer_sample(SAMPLE_MAX);
    wait_results_drained();
    reg_write(asam_pkg::REG_ALPHA, int'(asam_pkg::ONE_Q16) + 1);
    offer_sample(0);
    wait_results_drained();
    reg_write(asam_pkg::REG_ALPHA, 1);
    offer_sample(SAMPLE_MAX);
    wait_results_drained();
  endtask

  task automatic test_empty_range();
    reg_write(asam_pkg::REG_ALPHA, 40000);
    reg_write(asam_pkg::REG_MIN_LEVEL, 2000);
    reg_write(asam_pkg::REG_MAX_LEVEL, 2000);
    offer_sample(100);
    offer_sample(3000);
    wait_results_drained();
    reg_write(asam_pkg::REG_MIN_LEVEL, 3000);
    reg_write(asam_pkg::REG_MAX_LEVEL, 1000);
    offer_sample(SAMPLE_MAX);
    wait_results_drained();
    reg_write(asam_pkg::REG_MIN_LEVEL, SAMPLE_MAX);
    reg_write(asam_pkg::REG_MAX_LEVEL, 0);
    offer_sample(0);
    wait_results_drained();
  endtask

  task automatic test_extrapolation_saturation();
    reg_write(asam_pkg::REG_ALPHA, asam_pkg::ONE_Q16);
    reg_write(asam_pkg::REG_MIN_LEVEL, 2000);
    reg_write(asam_pkg::REG_MAX_LEVEL, 2001);
    reg_write(asam_pkg::REG_MIN_ANGLE, -46080);
    reg_write(asam_pkg::REG_MAX_ANGLE, 46080);
    offer_sample(SAMPLE_MAX);
    offer_sample(0);
    wait_results_drained();
    // reversed angle range
    reg_write(asam_pkg::REG_MIN_ANGLE, 46080);
    reg_write(asam_pkg::REG_MAX_ANGLE, -46080);
    offer_sample(1000);
    wait_results_drained();
    reg_write(asam_pkg::REG_ALPHA, 32768);
    offer_sample(2001);
    wait_results_drained();
    reg_write(asam_pkg::REG_MIN_ANGLE, -(1 << (asam_pkg::ANGLE_CFG_W - 1)));
    reg_write(asam_pkg::REG_MAX_ANGLE, (1 << (asam_pkg::ANGLE_CFG_W - 1)) - 1);
    offer_sample(SAMPLE_MAX);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    reg_write(asam_pkg::REG_ALPHA, 20000);
    reg_write(asam_pkg::REG_MIN_LEVEL, 1000);
    reg_write(asam_pkg::REG_MAX_LEVEL, 3000);
    reg_write(asam_pkg::REG_MIN_ANGLE, -30000);
    reg_write(asam_pkg::REG_MAX_ANGLE, 30000);
    no_idle = 1'b1;
    long_hold_req = 1'b1;
    repeat (16) offer_sample(random_sample());
    no_idle = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    repeat (RANDOM_PHASES) begin
      random_config();
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (PHASE_SAMPLES) offer_sample(random_sample());
      wait_results_drained();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    test_register_access();
    test_reset_mapping();
    test_alpha_extremes();
    test_empty_range();
    test_extrapolation_saturation();
    test_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/asam_pkg.sv
hdl/asam_regs.sv
hdl/asam_ctrl.sv
hdl/asam_datapath.sv
hdl/adc_smoothed_angle_mapper_top.sv
sim/tb.sv
